// File: rtl/core/nnta_pkg.sv
package nnta_pkg;

    localparam int MAX_TRACKS_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_PREDICT = 2'd1;
    localparam logic [1:0] CMD_DETECT  = 2'd2;

    localparam logic [1:0] REG_TIME_STEP = 2'd0;
    localparam logic [1:0] REG_GATE_COST = 2'd1;

    localparam logic [15:0] TIME_STEP_RST = 16'd256;
    localparam logic [23:0] GATE_COST_RST = 24'd2559744;

    localparam logic signed [25:0] RANGE_MAX = 26'sd8388607;
    localparam logic signed [25:0] RANGE_MIN = -26'sd8388608;

    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_ASSOC   = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_PREDICT,
        OP_DETECT,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [23:0] range;
        logic signed [15:0] velocity;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [23:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic               valid;
        logic               kind;
        logic [4:0]         track_id;
        logic               matched;
        logic signed [23:0] predicted_range;
        logic [23:0]        best_cost;
        logic               last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRD_RD,
        ST_PRD_MUL,
        ST_PRD_ADD,
        ST_DET_RD,
        ST_DET_CMP,
        ST_DET_OUT
    } state_t;

endpackage

// File: rtl/core/nnta_queue.sv
module nnta_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nnta_pkg::item_t push_item,
    input  logic           pop,
    output nnta_pkg::item_t head_item,
    output logic           empty,
    output logic           full
);

    localparam int PW = (nnta_pkg::QUEUE_DEPTH > 1) ? $clog2(nnta_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(nnta_pkg::QUEUE_DEPTH + 1);

    nnta_pkg::item_t slot_reg [nnta_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          do_push;
    logic          do_pop;

    assign empty     = (fill_reg == '0);
    assign full      = (fill_reg == CW'(nnta_pkg::QUEUE_DEPTH));
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(nnta_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(nnta_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/core/nnta_front.sv
module nnta_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         cmd,
    input  logic signed [23:0] meas_range,
    input  logic signed [15:0] meas_velocity,
    output logic               busy,
    input  logic               q_full,
    output logic               q_push,
    output nnta_pkg::item_t    q_item
);

    logic            held_valid_reg, held_valid_next;
    nnta_pkg::item_t held_reg;
    nnta_pkg::op_t   op_class;
    logic            take;

    always_comb
    begin
        unique case (cmd)
            nnta_pkg::CMD_LOAD:    op_class = nnta_pkg::OP_LOAD;
            nnta_pkg::CMD_PREDICT: op_class = nnta_pkg::OP_PREDICT;
            nnta_pkg::CMD_DETECT:  op_class = nnta_pkg::OP_DETECT;
            default:               op_class = nnta_pkg::OP_NONE;
        endcase
    end

    assign busy   = held_valid_reg && q_full;
    assign take   = start && !busy;
    assign q_push = held_valid_reg && !q_full;
    assign q_item = held_reg;

    // unknown commands are taken and dropped here
    always_comb
    begin
        held_valid_next = held_valid_reg;
        if (q_push)
        begin
            held_valid_next = 1'b0;
        end
        if (take)
        begin
            held_valid_next = (op_class != nnta_pkg::OP_NONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            held_reg.op       <= op_class;
            held_reg.range    <= meas_range;
            held_reg.velocity <= meas_velocity;
        end
    end

endmodule

// File: rtl/core/nnta_back.sv
module nnta_back
#(
    parameter int MAX_TRACKS = nnta_pkg::MAX_TRACKS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  nnta_pkg::cfg_wr_t cfg_wr,
    input  logic              q_empty,
    input  nnta_pkg::item_t   q_head,
    output logic              q_pop,
    output nnta_pkg::result_t result
);

    localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CW = $clog2(MAX_TRACKS + 1);

    nnta_pkg::state_t state_reg, state_next;

    logic [15:0]        time_step_reg;
    logic [23:0]        gate_cost_reg;
    logic [CW-1:0]      count_reg;
    logic [IW-1:0]      idx_reg;
    logic [IW-1:0]      best_idx_reg;
    logic signed [23:0] det_range_reg;
    logic signed [15:0] det_vel_reg;
    logic [23:0]        best_reg;
    logic signed [23:0] best_pred_reg;
    logic               found_reg;
    logic signed [32:0] prod_reg;

    logic signed [23:0] range_mem [MAX_TRACKS];
    logic signed [15:0] vel_mem   [MAX_TRACKS];
    logic signed [23:0] pred_mem  [MAX_TRACKS];
    logic [MAX_TRACKS-1:0] pred_valid_reg;
    logic signed [23:0] range_rd_reg;
    logic signed [15:0] vel_rd_reg;
    logic signed [23:0] pred_rd_reg;
    logic               pred_vld_rd_reg;

    logic               is_last;
    logic               table_full;
    logic               tab_we;
    logic [IW-1:0]      tab_waddr;
    logic signed [23:0] tab_wrange;
    logic signed [15:0] tab_wvel;
    logic               pred_we;
    logic signed [25:0] pred_sum;
    logic signed [23:0] pred_sat;
    logic signed [23:0] pred_cur;
    logic signed [24:0] diff;
    logic [24:0]        diff_abs;
    logic [23:0]        cost;
    nnta_pkg::result_t  result_next;
    nnta_pkg::result_t  result_reg;

    assign is_last    = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign table_full = (count_reg == CW'(MAX_TRACKS));

    assign pred_sum = {{2{range_rd_reg[23]}}, range_rd_reg}
                    + {prod_reg[32], prod_reg[32:8]};
    assign pred_sat = (pred_sum > nnta_pkg::RANGE_MAX) ? 24'sh7FFFFF
                    : (pred_sum < nnta_pkg::RANGE_MIN) ? -24'sh800000
                    : pred_sum[23:0];

    assign pred_cur = pred_vld_rd_reg ? pred_rd_reg : 24'sd0;
    assign diff     = {det_range_reg[23], det_range_reg} - {pred_cur[23], pred_cur};
    assign diff_abs = diff[24] ? 25'(-diff) : 25'(diff);
    assign cost     = diff_abs[23:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nnta_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_head.op)
                        nnta_pkg::OP_PREDICT:
                            state_next = (count_reg == '0) ? nnta_pkg::ST_IDLE
                                       : nnta_pkg::ST_PRD_RD;
                        nnta_pkg::OP_DETECT:
                            state_next = (count_reg == '0) ? nnta_pkg::ST_DET_OUT
                                       : nnta_pkg::ST_DET_RD;
                        default:
                            state_next = nnta_pkg::ST_IDLE;
                    endcase
                end
            end
            nnta_pkg::ST_PRD_RD:  state_next = nnta_pkg::ST_PRD_MUL;
            nnta_pkg::ST_PRD_MUL: state_next = nnta_pkg::ST_PRD_ADD;
            nnta_pkg::ST_PRD_ADD:
                state_next = is_last ? nnta_pkg::ST_IDLE : nnta_pkg::ST_PRD_RD;
            nnta_pkg::ST_DET_RD:  state_next = nnta_pkg::ST_DET_CMP;
            nnta_pkg::ST_DET_CMP:
                state_next = is_last ? nnta_pkg::ST_DET_OUT : nnta_pkg::ST_DET_RD;
            nnta_pkg::ST_DET_OUT: state_next = nnta_pkg::ST_IDLE;
            default:              state_next = nnta_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop       = 1'b0;
        tab_we      = 1'b0;
        tab_waddr   = best_idx_reg;
        tab_wrange  = det_range_reg;
        tab_wvel    = det_vel_reg;
        pred_we     = 1'b0;
        result_next = '0;
        unique case (state_reg)
            nnta_pkg::ST_IDLE:
            begin
                q_pop = !q_empty;
                if (!q_empty && (q_head.op == nnta_pkg::OP_LOAD) && !table_full)
                begin
                    tab_we     = 1'b1;
                    tab_waddr  = count_reg[IW-1:0];
                    tab_wrange = q_head.range;
                    tab_wvel   = q_head.velocity;
                end
            end
            nnta_pkg::ST_PRD_ADD:
            begin
                pred_we                     = 1'b1;
                result_next.valid           = 1'b1;
                result_next.kind            = nnta_pkg::KIND_PREDICT;
                result_next.track_id        = 5'(CW'(idx_reg) + CW'(1));
                result_next.predicted_range = pred_sat;
                result_next.last            = is_last;
            end
            nnta_pkg::ST_DET_OUT:
            begin
                tab_we                      = found_reg;
                result_next.valid           = 1'b1;
                result_next.kind            = nnta_pkg::KIND_ASSOC;
                result_next.last            = 1'b1;
                if (found_reg)
                begin
                    result_next.track_id        = 5'(CW'(best_idx_reg) + CW'(1));
                    result_next.matched         = 1'b1;
                    result_next.predicted_range = best_pred_reg;
                    result_next.best_cost       = best_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nnta_pkg::ST_IDLE;
            time_step_reg  <= nnta_pkg::TIME_STEP_RST;
            gate_cost_reg  <= nnta_pkg::GATE_COST_RST;
            count_reg      <= '0;
            pred_valid_reg <= '0;
            result_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            result_reg <= result_next;
            if (cfg_wr.valid && (cfg_wr.index == nnta_pkg::REG_TIME_STEP))
            begin
                time_step_reg <= cfg_wr.data[15:0];
            end
            if (cfg_wr.valid && (cfg_wr.index == nnta_pkg::REG_GATE_COST))
            begin
                gate_cost_reg <= cfg_wr.data;
            end
            if ((state_reg == nnta_pkg::ST_IDLE) && tab_we)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (pred_we)
            begin
                pred_valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            range_mem[tab_waddr] <= tab_wrange;
            vel_mem[tab_waddr]   <= tab_wvel;
        end
        if (pred_we)
        begin
            pred_mem[idx_reg] <= pred_sat;
        end
        range_rd_reg    <= range_mem[idx_reg];
        vel_rd_reg      <= vel_mem[idx_reg];
        pred_rd_reg     <= pred_mem[idx_reg];
        pred_vld_rd_reg <= pred_valid_reg[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            nnta_pkg::ST_IDLE:
            begin
                idx_reg       <= '0;
                best_idx_reg  <= '0;
                found_reg     <= 1'b0;
                best_reg      <= gate_cost_reg;
                det_range_reg <= q_head.range;
                det_vel_reg   <= q_head.velocity;
            end
            nnta_pkg::ST_PRD_MUL:
            begin
                prod_reg <= vel_rd_reg * $signed({1'b0, time_step_reg});
            end
            nnta_pkg::ST_PRD_ADD:
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            nnta_pkg::ST_DET_CMP:
            begin
                if (cost < best_reg)
                begin
                    best_reg      <= cost;
                    best_idx_reg  <= idx_reg;
                    best_pred_reg <= pred_cur;
                    found_reg     <= 1'b1;
                end
                idx_reg <= idx_reg + IW'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign result = result_reg;

endmodule

// File: rtl/core/nearest_neighbor_track_association.sv
// Nearest-neighbor track association, constant-velocity prediction.
// Input: a word is taken at a clock edge with start high and busy low.
//   cmd 0 loads a track (ignored when the table is full), 1 predicts all
//   tracks, 2 associates a detection, 3 is dropped. Words pass a holding
//   register and a two-word queue into the executor, so busy rises only
//   when both are occupied.
// Config: cfg_valid/cfg_ready write channel, cfg_ready always high.
//   Index 0 time_step, index 1 gate_cost; other indexes are ignored.
// Output: each result is shown for one cycle with result_valid high;
//   the receiver cannot stall, none is needed.
// Steps: a load is written from the idle state; a predict runs read,
//   multiply and add/saturate per track (one shared multiplier); a
//   detection runs read and compare per track, then the output state.
//   Results are registered. Tables are read through registered ports.
// Reset: track count zero, predictions read as zero via per-entry valid
//   bits, registers at dt = 1.0 and gate 9999.0.
module nearest_neighbor_track_association
#(
    parameter int MAX_TRACKS = nnta_pkg::MAX_TRACKS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         cmd,
    input  logic signed [23:0] meas_range,
    input  logic signed [15:0] meas_velocity,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    output logic               result_valid,
    output logic               kind,
    output logic [4:0]         track_id,
    output logic               matched,
    output logic signed [23:0] predicted_range,
    output logic [23:0]        best_cost,
    output logic               last
);

    nnta_pkg::item_t   push_item;
    nnta_pkg::item_t   head_item;
    nnta_pkg::cfg_wr_t cfg_wr;
    nnta_pkg::result_t result;
    logic              q_push;
    logic              q_pop;
    logic              q_empty;
    logic              q_full;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    nnta_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .meas_range    (meas_range),
        .meas_velocity (meas_velocity),
        .busy          (busy),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    nnta_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    nnta_back #(.MAX_TRACKS(MAX_TRACKS)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_wr  (cfg_wr),
        .q_empty (q_empty),
        .q_head  (head_item),
        .q_pop   (q_pop),
        .result  (result)
    );

    assign result_valid    = result.valid;
    assign kind            = result.kind;
    assign track_id        = result.track_id;
    assign matched         = result.matched;
    assign predicted_range = result.predicted_range;
    assign best_cost       = result.best_cost;
    assign last            = result.last;

endmodule
